/* src/nmva_pkg.sv */
// Shared types and constants for the N-of-M vote alert block.
package nmva_pkg;

  // Field widths of one verdict transaction and one result transaction.
  localparam int unsigned CfgW    = 5;
  localparam int unsigned CoolW   = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned VoteW   = 5;
  localparam int unsigned CfgIdxW = 2;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 72;

  // Bit positions inside the input tdata.
  localparam int unsigned InPosBit  = 0;
  localparam int unsigned InNowLsb  = 1;
  localparam int unsigned InTimeLsb = 33;
  localparam int unsigned InSuppBit = 97;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VOTES_NEEDED = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN_MS  = 2'd2;

  // Configuration reset values.
  localparam logic [CfgW-1:0]  WindowSizeRst  = 5'd5;
  localparam logic [CfgW-1:0]  VotesNeededRst = 5'd3;
  localparam logic [CoolW-1:0] CooldownRst    = 32'd1000;

  typedef logic [VoteW-1:0] vote_t;
  typedef logic [TimeW-1:0] time_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MASK,
    ST_VOTE,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // capture the incoming transaction
    logic mask_en;  // build the windowed verdict vector and cooldown check
    logic vote_en;  // count votes, decide the alert, read the oldest timestamp
    logic emit;     // load the output register
  } nmva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_supp;  // suppress flag of the transaction on the input
  } nmva_status_t;

endpackage

/* src/n_of_m_vote_alert_core.sv */
// Top level of the N-of-M sliding-window vote alert block.
//
//  Channel   Direction  Signals                      Contents
//  s_axis    in         tvalid tready tdata[103:0]   one window verdict
//  m_axis    out        tvalid tready tdata[71:0]    one alert result per verdict
//  cfg       in         cfg_we_i cfg_idx_i cfg_data_i register writes, no read-back
//
// A live verdict passes in order through acceptance with the ring write, windowing
// and cooldown check, vote count with timestamp memory read, and result load.
// A suppressed verdict goes from acceptance straight to result load.
// Reset clears the rings' fill state at once; there is no clearing pass.
// A full output register stalls the block in its last step; input is taken
// again once the result is loaded.
module n_of_m_vote_alert_core #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [nmva_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [nmva_pkg::CoolW-1:0]         cfg_data_i,
  // Verdict stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: positive[0], now_time_ms[32:1], window_time_us[96:33],
  // suppressed[97], zero fill[103:98]
  input  logic [nmva_pkg::InDataW-1:0]       s_axis_tdata,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: alert[0], first_positive_us[64:1], vote_count[69:65],
  // zero fill[71:70]
  output logic [nmva_pkg::OutDataW-1:0]      m_axis_tdata
);

  nmva_pkg::nmva_cmd_t    cmd;
  nmva_pkg::nmva_status_t status;

  nmva_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  nmva_dp #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

/* src/nmva_ctrl.sv */
// Controller state machine of the N-of-M vote alert block.
module nmva_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  nmva_pkg::nmva_status_t status_i,
  output nmva_pkg::nmva_cmd_t    cmd_o
);

  nmva_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             load_ok;

  assign accept  = s_axis_tvalid && s_axis_tready;
  // The output register can take a new result when empty or being drained.
  assign load_ok = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nmva_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = status_i.in_supp ? nmva_pkg::ST_EMIT : nmva_pkg::ST_MASK;
        end
      end
      nmva_pkg::ST_MASK: state_d = nmva_pkg::ST_VOTE;
      nmva_pkg::ST_VOTE: state_d = nmva_pkg::ST_EMIT;
      nmva_pkg::ST_EMIT: begin
        if (load_ok) begin
          state_d = nmva_pkg::ST_IDLE;
        end
      end
      default: state_d = nmva_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    s_axis_tready  = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      nmva_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      nmva_pkg::ST_MASK: cmd_o.mask_en = 1'b1;
      nmva_pkg::ST_VOTE: cmd_o.vote_en = 1'b1;
      nmva_pkg::ST_EMIT: cmd_o.emit    = load_ok;
      default: ;
    endcase
  end

  // Output valid flag: set on a load, cleared when the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nmva_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A live verdict walks through the evaluation stages.
  a_live_to_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status_i.in_supp) |=> (state_q == nmva_pkg::ST_MASK))
    else $error("live verdict did not enter the mask stage");

  a_mask_to_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nmva_pkg::ST_MASK) |=> (state_q == nmva_pkg::ST_VOTE))
    else $error("mask stage not followed by vote stage");

  // A result loaded into the output register is offered next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> m_axis_tvalid)
    else $error("loaded result not offered");

  // A blocked result waits in the emit state.
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nmva_pkg::ST_EMIT && !load_ok) |=> (state_q == nmva_pkg::ST_EMIT))
    else $error("emit state left while output register was full");
`endif

endmodule

/* src/nmva_dp.sv */
// Datapath of the N-of-M vote alert block: rings, vote count and cooldown.
module nmva_dp #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nmva_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [nmva_pkg::CoolW-1:0]        cfg_data_i,
  input  logic [nmva_pkg::InDataW-1:0]      s_axis_tdata,
  output logic [nmva_pkg::OutDataW-1:0]     m_axis_tdata,
  input  nmva_pkg::nmva_cmd_t               cmd_i,
  output nmva_pkg::nmva_status_t            status_o
);

  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned CmpW = (CntW > nmva_pkg::CfgW) ? CntW : nmva_pkg::CfgW;
  localparam int unsigned AddrW = $clog2(2 * MAX_WINDOWS);

  typedef logic [MAX_WINDOWS-1:0] vec_t;
  typedef logic [CmpW-1:0]        cmp_t;
  typedef logic [CntW-1:0]        cnt_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [AddrW-1:0]       addr_t;

  localparam cmp_t  MaxCmp  = cmp_t'(MAX_WINDOWS);
  localparam cmp_t  OneCmp  = cmp_t'(1);
  localparam cnt_t  MaxCnt  = cnt_t'(MAX_WINDOWS);
  localparam idx_t  LastIdx = idx_t'(MAX_WINDOWS - 1);
  localparam addr_t MaxAddr = addr_t'(MAX_WINDOWS);
  localparam addr_t MaxM1   = addr_t'(MAX_WINDOWS - 1);

  // Input field unpacking.
  logic                       in_pos;
  logic [nmva_pkg::CoolW-1:0] in_now;
  nmva_pkg::time_t            in_time;
  logic                       in_supp;

  assign in_pos  = s_axis_tdata[nmva_pkg::InPosBit];
  assign in_now  = s_axis_tdata[nmva_pkg::InNowLsb +: nmva_pkg::CoolW];
  assign in_time = s_axis_tdata[nmva_pkg::InTimeLsb +: nmva_pkg::TimeW];
  assign in_supp = s_axis_tdata[nmva_pkg::InSuppBit];
  assign status_o.in_supp = in_supp;

  // Configuration registers.
  logic [nmva_pkg::CfgW-1:0]  win_q, votes_cfg_q;
  logic [nmva_pkg::CoolW-1:0] cool_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= nmva_pkg::WindowSizeRst;
      votes_cfg_q <= nmva_pkg::VotesNeededRst;
      cool_cfg_q  <= nmva_pkg::CooldownRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nmva_pkg::CFG_WINDOW_SIZE:  win_q       <= cfg_data_i[nmva_pkg::CfgW-1:0];
        nmva_pkg::CFG_VOTES_NEEDED: votes_cfg_q <= cfg_data_i[nmva_pkg::CfgW-1:0];
        nmva_pkg::CFG_COOLDOWN_MS:  cool_cfg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective window size and threshold after clamping.
  cmp_t m_eff, n_eff, win_ext, votes_ext;
  always_comb begin
    win_ext   = cmp_t'(win_q);
    votes_ext = cmp_t'(votes_cfg_q);
    if (win_ext == '0) begin
      m_eff = OneCmp;
    end else if (win_ext > MaxCmp) begin
      m_eff = MaxCmp;
    end else begin
      m_eff = win_ext;
    end
    if (votes_ext == '0) begin
      n_eff = OneCmp;
    end else if (votes_ext > m_eff) begin
      n_eff = m_eff;
    end else begin
      n_eff = votes_ext;
    end
  end

  // Verdict ring kept in age order: bit 0 is the newest entry.
  vec_t age_q;
  idx_t wr_idx_q;
  cnt_t fill_q;
  logic supp_q;
  logic [nmva_pkg::CoolW-1:0] now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q    <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (cmd_i.accept && !in_supp) begin
      age_q    <= vec_t'({age_q, in_pos});
      wr_idx_q <= (wr_idx_q == LastIdx) ? '0 : wr_idx_q + idx_t'(1);
      if (fill_q != MaxCnt) begin
        fill_q <= fill_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      supp_q <= in_supp;
      now_q  <= in_now;
    end
  end

  // Timestamp memory, written at the ring slot on acceptance and read in the vote stage.
  nmva_pkg::time_t time_mem [MAX_WINDOWS];
  nmva_pkg::time_t rd_q;
  addr_t           rd_sum;
  idx_t            rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !in_supp) begin
      time_mem[wr_idx_q] <= in_time;
    end
  end

  // Mask stage: keep the last k verdicts and check the cooldown.
  cmp_t k_cmp;
  cnt_t k_cnt;
  vec_t win_vec;
  vec_t masked_q;
  logic cool_ok_q;
  logic alerted_q;
  logic [nmva_pkg::CoolW-1:0] last_alert_q;
  logic [nmva_pkg::CoolW-1:0] since_alert;

  assign k_cmp       = (cmp_t'(fill_q) < m_eff) ? cmp_t'(fill_q) : m_eff;
  assign k_cnt       = cnt_t'(k_cmp);
  assign since_alert = now_q - last_alert_q;

  always_comb begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      win_vec[i] = age_q[i] && (cnt_t'(i) < k_cnt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mask_en) begin
      masked_q  <= win_vec;
      cool_ok_q <= !alerted_q || (since_alert >= cool_cfg_q);
    end
  end

  // Vote stage: count positives and locate the oldest one.
  cnt_t votes;
  idx_t oldest;
  logic alert_now;
  cnt_t votes_q;
  logic alert_q;

  always_comb begin
    votes  = '0;
    oldest = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      votes = votes + cnt_t'(masked_q[i]);
      if (masked_q[i]) begin
        oldest = idx_t'(i);
      end
    end
  end

  assign alert_now = (cmp_t'(votes) >= n_eff) && cool_ok_q;

  // Slot of the entry 'oldest' steps back from the newest one.
  always_comb begin
    rd_sum = addr_t'(wr_idx_q) + MaxM1 - addr_t'(oldest);
    if (rd_sum >= MaxAddr) begin
      rd_sum = rd_sum - MaxAddr;
    end
    rd_addr = idx_t'(rd_sum);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vote_en) begin
      votes_q <= votes;
      alert_q <= alert_now;
      rd_q    <= time_mem[rd_addr];
    end
  end

  // Alert history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alerted_q    <= 1'b0;
      last_alert_q <= '0;
    end else if (cmd_i.vote_en && alert_now) begin
      alerted_q    <= 1'b1;
      last_alert_q <= now_q;
    end
  end

  // Output register; a suppressed verdict gives an all-zero result.
  logic            out_alert_q;
  nmva_pkg::time_t out_first_q;
  nmva_pkg::vote_t out_votes_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_alert_q <= alert_q && !supp_q;
      out_first_q <= (alert_q && !supp_q) ? rd_q : '0;
      out_votes_q <= supp_q ? '0 : nmva_pkg::vote_t'(votes_q);
    end
  end

  assign m_axis_tdata = {2'b00, out_votes_q, out_first_q, out_alert_q};

endmodule
